### sv/assert_macros.svh
// assertion helpers used by the cfea_checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is high
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// clocked check that also runs through reset
`define ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

### sv/cfea_pkg.sv
package cfea_pkg;

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int ACC_WIDTH_DEF = 64;
   localparam int D_W = 33;
   localparam int Q_W = 16;
   localparam int CHARGE_FRAC = 12;
   localparam int OUT_FRAC = 32;
   localparam int UNIT_FRAC = 16;
   localparam logic [31:0] UNIT_RESET = 32'd21762644;

   // one classified atom as it travels from front to back
   typedef struct packed {
      logic signed [D_W-1:0] dx;
      logic signed [D_W-1:0] dy;
      logic signed [D_W-1:0] dz;
      logic signed [Q_W-1:0] charge;
      logic                  last;
      logic                  zero;
   } atom_type;

   typedef enum logic [3:0] {
      B_IDLE, B_LSQ, B_SQ, B_SQRT, B_EDIV, B_LH, B_HMUL,
      B_HDIV, B_FDIV, B_FIN, B_LSC, B_SCALE, B_OUT
   } back_state_type;

   // clamp a magnitude with sign into the accumulator range
   function automatic logic signed [63:0] sat_signed(input logic [127:0] mag,
                                                     input logic neg,
                                                     input int unsigned acc_w);
      logic [63:0] lim;
      logic [63:0] m;
      lim = (64'd1 << (acc_w - 1)) - 64'd1 + {63'd0, neg};
      m = (mag > {64'd0, lim}) ? lim : mag[63:0];
      sat_signed = neg ? -$signed(m) : $signed(m);
   endfunction

   // saturating add in the accumulator range
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input int unsigned acc_w);
      logic signed [64:0] s;
      logic signed [64:0] hi;
      logic signed [64:0] lo;
      hi = $signed((65'd1 << (acc_w - 1)) - 65'd1);
      lo = -hi - 65'sd1;
      s = 65'(a) + 65'(b);
      if (s > hi) sat_add = hi[63:0];
      else if (s < lo) sat_add = lo[63:0];
      else sat_add = s[63:0];
   endfunction

   function automatic logic [D_W-1:0] abs_d(input logic signed [D_W-1:0] v);
      abs_d = v[D_W-1] ? D_W'(-v) : D_W'(v);
   endfunction

endpackage

### sv/coulomb_force_energy_accumulator_unit.sv
// each atom runs through the back sequencer: three squares, a square root, an energy division
// and per axis a multiply and two divisions
// an atom at zero distance goes straight to the finish state; a last atom adds four scaling passes
// front stage plus a two-entry queue take up to three atoms while the back end works or stalls
// synchronous active-high reset clears sums, flag, queue and sets unit_factor to 332.0716
module coulomb_force_energy_accumulator_unit #(
   parameter int COORD_FRAC_BITS = cfea_pkg::COORD_FRAC_BITS_DEF,
   parameter int ACC_WIDTH = cfea_pkg::ACC_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // probe_x, probe_y, probe_z, atom_x, atom_y, atom_z, atom_charge
   input  logic [207:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x, force_y, force_z, energy
   output logic [255:0] rsp_tdata,
   // zero_distance_seen
   output logic         rsp_tuser
);

   logic               f_valid, f_ready, q_valid, q_ready;
   cfea_pkg::atom_type f_data, q_data;

   cfea_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_tdata), .in_last(req_tlast),
      .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data)
   );

   cfea_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   cfea_back #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)
   ) u_back (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_data(rsp_tdata), .out_zero(rsp_tuser)
   );

endmodule

### sv/cfea_front.sv
module cfea_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [207:0]        in_data,
   input  logic                in_last,
   output logic                push_valid,
   input  logic                push_ready,
   output cfea_pkg::atom_type  push_data
);

   logic               vld_ff;
   cfea_pkg::atom_type item_ff;
   cfea_pkg::atom_type item_in;

   // connector from atom to probe and the zero-distance mark
   always_comb begin
      item_in.dx = 33'($signed(in_data[31:0])) - 33'($signed(in_data[127:96]));
      item_in.dy = 33'($signed(in_data[63:32])) - 33'($signed(in_data[159:128]));
      item_in.dz = 33'($signed(in_data[95:64])) - 33'($signed(in_data[191:160]));
      item_in.charge = $signed(in_data[207:192]);
      item_in.last = in_last;
      item_in.zero = (item_in.dx == '0) && (item_in.dy == '0) && (item_in.dz == '0);
   end

   assign in_ready = !vld_ff || push_ready;
   assign push_valid = vld_ff;
   assign push_data = item_ff;

   // one holding stage in front of the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         vld_ff <= 1'b1;
      end else if (push_ready) begin
         vld_ff <= 1'b0;
      end
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

### sv/cfea_queue.sv
module cfea_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cfea_pkg::atom_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output cfea_pkg::atom_type  out_data
);

   cfea_pkg::atom_type ent_ff [2];
   logic       wptr_ff;
   logic       rptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign in_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data = ent_ff[rptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   // two-entry ring of atoms
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop) rptr_ff <= !rptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         ent_ff[wptr_ff] <= in_data;
      end
   end

endmodule

### sv/cfea_back.sv
module cfea_back #(
   parameter int COORD_FRAC_BITS = cfea_pkg::COORD_FRAC_BITS_DEF,
   parameter int ACC_WIDTH = cfea_pkg::ACC_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  cfea_pkg::atom_type  pop_data,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [255:0]        out_data,
   output logic                out_zero
);

   localparam int E_W = cfea_pkg::Q_W + cfea_pkg::OUT_FRAC - cfea_pkg::CHARGE_FRAC
                        + COORD_FRAC_BITS;
   localparam int MA_W = (E_W > ACC_WIDTH) ? E_W : ACC_WIDTH;
   localparam int MB_W = cfea_pkg::D_W;
   localparam int MP_W = MA_W + MB_W;
   localparam int S_W = E_W + cfea_pkg::D_W + COORD_FRAC_BITS;
   localparam int R2_W = 68;
   localparam int RT_W = R2_W / 2;
   localparam int SQ_REM_W = RT_W + 4;
   localparam int DR_W = RT_W + 2;
   localparam int CNT_W = $clog2(S_W);
   localparam int E_SHIFT = cfea_pkg::OUT_FRAC - cfea_pkg::CHARGE_FRAC + COORD_FRAC_BITS;

   cfea_pkg::back_state_type state_ff, state_in;

   logic [31:0]                 uf_ff;
   logic signed [cfea_pkg::D_W-1:0] d_ff [3];
   logic [cfea_pkg::Q_W-1:0]    qmag_ff;
   logic                        qneg_ff;
   logic                        last_ff;
   logic [1:0]                  axis_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [R2_W-1:0]             r2_ff;
   logic [RT_W-1:0]             r_ff;
   logic [E_W-1:0]              e_ff;
   logic signed [ACC_WIDTH-1:0] sum_ff [4];
   logic signed [63:0]          res_ff [4];
   logic                        zflag_ff;
   logic                        ovld_ff;
   logic [255:0]                odata_ff;
   logic                        ozero_ff;

   // shared shift-add multiplier
   logic [MP_W-1:0] ma_ff, mp_ff, mp_in;
   logic [MB_W-1:0] mb_ff;
   // shared restoring divider
   logic [S_W-1:0]  dn_ff, dq_ff, dq_in;
   logic [DR_W-1:0] dr_ff, dr_in;
   logic [DR_W-1:0] dt;
   logic            dge;
   // digit-by-digit square root
   logic [R2_W-1:0]     rad_ff;
   logic [SQ_REM_W-1:0] srem_ff, st, strial;
   logic [RT_W-1:0]     root_ff, root_in;
   logic                sge;

   logic mul_done, sqrt_done, div_done;
   logic signed [63:0] cur_sum;
   logic [ACC_WIDTH-1:0] cur_mag;
   logic [127:0] scaled_mag;
   logic load_out;

   // datapath step values
   always_comb begin
      mp_in = mp_ff + (mb_ff[0] ? ma_ff : '0);
      dt = {dr_ff[DR_W-2:0], dn_ff[S_W-1]};
      dge = (dt >= DR_W'(r_ff));
      dr_in = dge ? dt - DR_W'(r_ff) : dt;
      dq_in = {dq_ff[S_W-2:0], dge};
      st = {srem_ff[SQ_REM_W-3:0], rad_ff[R2_W-1 -: 2]};
      strial = SQ_REM_W'({root_ff, 2'b01});
      sge = (st >= strial);
      root_in = {root_ff[RT_W-2:0], sge};
      cur_sum = 64'(sum_ff[axis_ff]);
      cur_mag = cur_sum[63] ? ACC_WIDTH'(-cur_sum) : ACC_WIDTH'(cur_sum);
      scaled_mag = 128'(mp_in) >> cfea_pkg::UNIT_FRAC;
      mul_done = (cnt_ff == CNT_W'(MB_W - 1));
      sqrt_done = (cnt_ff == CNT_W'(RT_W - 1));
      div_done = (cnt_ff == CNT_W'(S_W - 1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfea_pkg::B_IDLE:
            if (pop_valid) state_in = pop_data.zero ? cfea_pkg::B_FIN : cfea_pkg::B_LSQ;
         cfea_pkg::B_LSQ: state_in = cfea_pkg::B_SQ;
         cfea_pkg::B_SQ:
            if (mul_done) state_in = (axis_ff == 2'd2) ? cfea_pkg::B_SQRT : cfea_pkg::B_LSQ;
         cfea_pkg::B_SQRT: if (sqrt_done) state_in = cfea_pkg::B_EDIV;
         cfea_pkg::B_EDIV: if (div_done) state_in = cfea_pkg::B_LH;
         cfea_pkg::B_LH: state_in = cfea_pkg::B_HMUL;
         cfea_pkg::B_HMUL: if (mul_done) state_in = cfea_pkg::B_HDIV;
         cfea_pkg::B_HDIV: if (div_done) state_in = cfea_pkg::B_FDIV;
         cfea_pkg::B_FDIV:
            if (div_done) state_in = (axis_ff == 2'd2) ? cfea_pkg::B_FIN : cfea_pkg::B_LH;
         cfea_pkg::B_FIN: state_in = last_ff ? cfea_pkg::B_LSC : cfea_pkg::B_IDLE;
         cfea_pkg::B_LSC: state_in = cfea_pkg::B_SCALE;
         cfea_pkg::B_SCALE:
            if (mul_done) state_in = (axis_ff == 2'd3) ? cfea_pkg::B_OUT : cfea_pkg::B_LSC;
         cfea_pkg::B_OUT: if (!ovld_ff) state_in = cfea_pkg::B_IDLE;
         default: state_in = cfea_pkg::B_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop_ready = (state_ff == cfea_pkg::B_IDLE);
      load_out = (state_ff == cfea_pkg::B_OUT) && !ovld_ff;
   end

   assign out_valid = ovld_ff;
   assign out_data = odata_ff;
   assign out_zero = ozero_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfea_pkg::B_IDLE;
         uf_ff <= cfea_pkg::UNIT_RESET;
         ovld_ff <= 1'b0;
         zflag_ff <= 1'b0;
         for (int i = 0; i < 4; i++) sum_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) uf_ff <= csr_wr_data;
         if (load_out) ovld_ff <= 1'b1;
         else if (out_ready) ovld_ff <= 1'b0;
         // accumulate terms
         if (state_ff == cfea_pkg::B_IDLE && pop_valid && pop_data.zero) zflag_ff <= 1'b1;
         if (state_ff == cfea_pkg::B_EDIV && div_done) begin
            sum_ff[3] <= ACC_WIDTH'(cfea_pkg::sat_add(64'(sum_ff[3]),
               cfea_pkg::sat_signed(128'(dq_in), qneg_ff, ACC_WIDTH), ACC_WIDTH));
         end
         if (state_ff == cfea_pkg::B_FDIV && div_done) begin
            sum_ff[axis_ff] <= ACC_WIDTH'(cfea_pkg::sat_add(cur_sum,
               cfea_pkg::sat_signed(128'(dq_in), qneg_ff ^ d_ff[axis_ff][cfea_pkg::D_W-1],
                                    ACC_WIDTH), ACC_WIDTH));
         end
         if (load_out) begin
            zflag_ff <= 1'b0;
            for (int i = 0; i < 4; i++) sum_ff[i] <= '0;
         end
      end
   end

   // sequencer datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_ff + CNT_W'(1);
      ma_ff <= ma_ff << 1;
      mb_ff <= mb_ff >> 1;
      mp_ff <= mp_in;
      dn_ff <= dn_ff << 1;
      dr_ff <= dr_in;
      dq_ff <= dq_in;
      rad_ff <= rad_ff << 2;
      srem_ff <= sge ? st - strial : st;
      root_ff <= root_in;
      case (state_ff)
         cfea_pkg::B_IDLE: begin
            d_ff[0] <= pop_data.dx;
            d_ff[1] <= pop_data.dy;
            d_ff[2] <= pop_data.dz;
            qmag_ff <= pop_data.charge[cfea_pkg::Q_W-1] ? cfea_pkg::Q_W'(-pop_data.charge)
                                                         : cfea_pkg::Q_W'(pop_data.charge);
            qneg_ff <= pop_data.charge[cfea_pkg::Q_W-1];
            last_ff <= pop_data.last;
            axis_ff <= 2'd0;
            r2_ff <= '0;
         end
         cfea_pkg::B_LSQ, cfea_pkg::B_LH: begin
            ma_ff <= (state_ff == cfea_pkg::B_LSQ) ? MP_W'(cfea_pkg::abs_d(d_ff[axis_ff]))
                                                   : MP_W'(e_ff);
            mb_ff <= cfea_pkg::abs_d(d_ff[axis_ff]);
            mp_ff <= '0;
            cnt_ff <= '0;
         end
         cfea_pkg::B_SQ: begin
            if (mul_done) begin
               r2_ff <= r2_ff + mp_in[R2_W-1:0];
               rad_ff <= r2_ff + mp_in[R2_W-1:0];
               srem_ff <= '0;
               root_ff <= '0;
               cnt_ff <= '0;
               if (axis_ff != 2'd2) axis_ff <= axis_ff + 2'd1;
            end
         end
         cfea_pkg::B_SQRT: begin
            if (sqrt_done) begin
               r_ff <= root_in;
               dn_ff <= S_W'(qmag_ff) << E_SHIFT;
               dr_ff <= '0;
               cnt_ff <= '0;
            end
         end
         cfea_pkg::B_EDIV: begin
            if (div_done) begin
               e_ff <= dq_in[E_W-1:0];
               axis_ff <= 2'd0;
            end
         end
         cfea_pkg::B_HMUL: begin
            if (mul_done) begin
               dn_ff <= S_W'(mp_in);
               dr_ff <= '0;
               cnt_ff <= '0;
            end
         end
         cfea_pkg::B_HDIV: begin
            if (div_done) begin
               dn_ff <= dq_in << COORD_FRAC_BITS;
               dr_ff <= '0;
               cnt_ff <= '0;
            end
         end
         cfea_pkg::B_FDIV: begin
            if (div_done && axis_ff != 2'd2) axis_ff <= axis_ff + 2'd1;
         end
         cfea_pkg::B_FIN: axis_ff <= 2'd0;
         cfea_pkg::B_LSC: begin
            ma_ff <= MP_W'(cur_mag);
            mb_ff <= MB_W'(uf_ff);
            mp_ff <= '0;
            cnt_ff <= '0;
         end
         cfea_pkg::B_SCALE: begin
            if (mul_done) begin
               res_ff[axis_ff] <= cfea_pkg::sat_signed(scaled_mag, cur_sum[63], ACC_WIDTH);
               if (axis_ff != 2'd3) axis_ff <= axis_ff + 2'd1;
            end
         end
         default: ;
      endcase
      // result register
      if (load_out) begin
         odata_ff <= {res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
         ozero_ff <= zflag_ff;
      end
   end

endmodule

### sv/cfea_checker.sv
`include "assert_macros.svh"

module cfea_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [255:0] rsp_tdata
);

   logic [2:0] pend_ff;

   // last atoms taken whose result is not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'd0;
      end else begin
         pend_ff <= pend_ff + {2'd0, req_tvalid && req_tready && req_tlast}
                            - {2'd0, rsp_tvalid && rsp_tready};
      end
   end

   `ASSERT_RST(a_reset_idle, reset |=> !rsp_tvalid)
   `ASSERT_CLK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `ASSERT_CLK(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   `ASSERT_CLK(a_rsp_has_last, rsp_tvalid |-> pend_ff != 3'd0)

endmodule

bind coulomb_force_energy_accumulator_unit cfea_checker u_chk (.*);

### tb/sv/energy_checker.sv
`timescale 1ns / 1ps

module energy_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [207:0] req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [255:0] rsp_tdata,
   input  logic         rsp_tuser,
   output int           errors,
   output int           pending
);

   localparam int FRAC = cfea_pkg::COORD_FRAC_BITS_DEF;
   localparam int ENERGY_SHIFT = cfea_pkg::OUT_FRAC - cfea_pkg::CHARGE_FRAC + FRAC;

   typedef struct packed {
      logic signed [63:0] force_x;
      logic signed [63:0] force_y;
      logic signed [63:0] force_z;
      logic signed [63:0] energy;
      logic               zero_seen;
   } potential_sum_type;

   potential_sum_type expected_sums[$];

   logic signed [63:0] sum_fx, sum_fy, sum_fz, sum_energy;
   logic               sum_zero;
   logic [31:0]        factor;

   // magnitude plus sign clamped into the signed 64 bit range
   function automatic logic signed [63:0] clamp_mag(input logic [127:0] mag, input logic neg);
      logic [127:0] lim;
      lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
      if (mag > lim) mag = lim;
      return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
   endfunction

   function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? -v : v;
      return m;
   endfunction

   // integer square root, result fits in 34 bits
   function automatic logic [127:0] int_root(input logic [127:0] n);
      logic [127:0] res;
      logic [127:0] c;
      res = '0;
      for (int b = 33; b >= 0; b--) begin
         c = res | (128'd1 << b);
         if (c * c <= n) res = c;
      end
      return res;
   endfunction

   function automatic logic signed [63:0] force_part(input logic [127:0] e,
                                                     input logic signed [63:0] d,
                                                     input logic qneg,
                                                     input logic [127:0] r);
      logic [127:0] h;
      h = (e * {64'd0, abs64(d)}) / r;
      h = h << FRAC;
      return clamp_mag(h / r, qneg != d[63]);
   endfunction

   function automatic logic signed [63:0] scale_out(input logic signed [63:0] v,
                                                    input logic [31:0] f);
      logic [127:0] p;
      p = ({64'd0, abs64(v)} * {96'd0, f}) >> cfea_pkg::UNIT_FRAC;
      return clamp_mag(p, v[63]);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      errors++;
   endtask

   logic signed [63:0] dx, dy, dz, q;
   logic [127:0]       r2, r, num, e;
   potential_sum_type  got, want;

   always @(posedge clock) begin
      if (reset) begin
         sum_fx = '0; sum_fy = '0; sum_fz = '0; sum_energy = '0;
         sum_zero = 1'b0;
         factor = cfea_pkg::UNIT_RESET;
         errors = 0;
         expected_sums.delete();
      end else begin
         if (csr_wr_en) factor = csr_wr_data;
         // accumulate one accepted atom
         if (req_tvalid && req_tready) begin
            dx = 64'($signed(req_tdata[31:0])) - 64'($signed(req_tdata[127:96]));
            dy = 64'($signed(req_tdata[63:32])) - 64'($signed(req_tdata[159:128]));
            dz = 64'($signed(req_tdata[95:64])) - 64'($signed(req_tdata[191:160]));
            q = 64'($signed(req_tdata[207:192]));
            r2 = {64'd0, abs64(dx)} * {64'd0, abs64(dx)}
               + {64'd0, abs64(dy)} * {64'd0, abs64(dy)}
               + {64'd0, abs64(dz)} * {64'd0, abs64(dz)};
            r = int_root(r2);
            if (r == 0) begin
               sum_zero = 1'b1;
            end else begin
               num = {64'd0, abs64(q)} << ENERGY_SHIFT;
               e = num / r;
               sum_energy = add_clamp(sum_energy, clamp_mag(e, q[63]));
               sum_fx = add_clamp(sum_fx, force_part(e, dx, q[63], r));
               sum_fy = add_clamp(sum_fy, force_part(e, dy, q[63], r));
               sum_fz = add_clamp(sum_fz, force_part(e, dz, q[63], r));
            end
            if (req_tlast) begin
               want.force_x = scale_out(sum_fx, factor);
               want.force_y = scale_out(sum_fy, factor);
               want.force_z = scale_out(sum_fz, factor);
               want.energy = scale_out(sum_energy, factor);
               want.zero_seen = sum_zero;
               expected_sums.push_back(want);
               sum_fx = '0; sum_fy = '0; sum_fz = '0; sum_energy = '0;
               sum_zero = 1'b0;
            end
         end
         // compare one accepted result
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sums.size() == 0) begin
               report_mismatch("unexpected result item", 64'd0, 64'd0);
            end else begin
               want = expected_sums.pop_front();
               got.force_x = rsp_tdata[63:0];
               got.force_y = rsp_tdata[127:64];
               got.force_z = rsp_tdata[191:128];
               got.energy = rsp_tdata[255:192];
               got.zero_seen = rsp_tuser;
               if (got.force_x !== want.force_x)
                  report_mismatch("force_x", got.force_x, want.force_x);
               if (got.force_y !== want.force_y)
                  report_mismatch("force_y", got.force_y, want.force_y);
               if (got.force_z !== want.force_z)
                  report_mismatch("force_z", got.force_z, want.force_z);
               if (got.energy !== want.energy)
                  report_mismatch("energy", got.energy, want.energy);
               if (got.zero_seen !== want.zero_seen)
                  report_mismatch("zero_distance_seen", 64'(got.zero_seen),
                                  64'(want.zero_seen));
            end
         end
      end
      pending = expected_sums.size();
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int IDLE_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 1300;
   localparam int RANDOM_ITEMS = 1500;
   localparam int NUM_PHASES = 6;

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [31:0]  csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [207:0] req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [255:0] rsp_tdata;
   logic         rsp_tuser;
   int           errors;
   int           pending;

   coulomb_force_energy_accumulator_unit DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   energy_checker checker_inst (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls: always ready, coin flip, or long stalls
   int ready_mode;
   int mode_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_mode <= 0;
         mode_left <= 0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 39) == 0);
         endcase
      end
   end

   // no-progress watchdog
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   int burst_left;

   // one atom item, then maybe a gap when the burst runs out
   task automatic send_atom(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input logic [31:0] ax,
                            input logic [31:0] ay, input logic [31:0] az,
                            input logic [15:0] q, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {q, az, ay, ax, pz, py, px};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_and_set(input logic [31:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // extremes, tiny distances for saturation, zero distance, zero charge
   task automatic directed_atoms();
      logic [31:0] p;
      p = $urandom;
      send_atom(0, 0, 0, 0, 0, 0, 16'h7fff, 1'b1);
      send_atom(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 16'h8000, 1'b0);
      send_atom(0, 32'h80000000, 0, 0, 32'h7fffffff, 0, 16'h7fff, 1'b0);
      send_atom(0, 0, 32'h7fffffff, 0, 0, 32'h80000000, 16'h0001, 1'b1);
      send_atom(1, 0, 0, 0, 0, 0, 16'h7fff, 1'b0);
      send_atom(0, 1, 0, 0, 0, 0, 16'h7fff, 1'b1);
      send_atom(0, 0, 0, 1, 0, 0, 16'h8000, 1'b0);
      send_atom(0, 0, 0, 0, 0, 1, 16'h8000, 1'b1);
      send_atom($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 16'h0000, 1'b1);
      send_atom(32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 16'h1000, 1'b0);
      send_atom(p, p, p, p, p, p, 16'h1234, 1'b1);
      send_atom(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 16'hffff, 1'b1);
   endtask

   // mostly molecules of a few atoms; positions wide, near or coincident
   task automatic random_atoms(input int count);
      int sent;
      int run_len;
      int kind;
      logic [31:0] px, py, pz, ax, ay, az;
      logic last;
      sent = 0;
      while (sent < count) begin
         run_len = $urandom_range(1, 6);
         px = $urandom; py = $urandom; pz = $urandom;
         if ($urandom_range(0, 3) == 0) begin
            px = $urandom_range(0, 32'h1fffff) - 32'h100000;
            py = $urandom_range(0, 32'h1fffff) - 32'h100000;
            pz = $urandom_range(0, 32'h1fffff) - 32'h100000;
         end
         for (int i = 0; i < run_len; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
               ax = $urandom; ay = $urandom; az = $urandom;
            end else if (kind < 8) begin
               ax = px + $urandom_range(0, 32'h3fffff) - 32'h200000;
               ay = py + $urandom_range(0, 32'h3fffff) - 32'h200000;
               az = pz + $urandom_range(0, 32'h3fffff) - 32'h200000;
            end else if (kind < 9) begin
               ax = px + $urandom_range(0, 4) - 2;
               ay = py + $urandom_range(0, 4) - 2;
               az = pz + $urandom_range(0, 4) - 2;
            end else begin
               ax = px; ay = py; az = pz;
            end
            last = (i == run_len - 1);
            if ($urandom_range(0, 19) == 0) last = 1'($urandom_range(0, 1));
            send_atom(px, py, pz, ax, ay, az, 16'($urandom), last);
            sent++;
         end
      end
   endtask

   logic [31:0] phase_factor[NUM_PHASES];

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      burst_left = 0;
      phase_factor[0] = cfea_pkg::UNIT_RESET;
      phase_factor[1] = 32'hffffffff;
      phase_factor[2] = 32'd0;
      phase_factor[3] = 32'd910527594;
      phase_factor[4] = 32'd1;
      phase_factor[5] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) drain_and_set(phase_factor[ph]);
         if (ph < 2) directed_atoms();
         random_atoms(RANDOM_ITEMS / NUM_PHASES);
         // close any open molecule so every phase ends idle
         send_atom($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   16'($urandom), 1'b1);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
